// ----- design/utf8_enc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_enc_pkg
// Shared widths, range limits and lead-byte marks for the UTF-8 encoder.
// ----------------------------------------------------------------------------
package utf8_enc_pkg;

	localparam int CP_W    = 32;
	localparam int LEN_W   = 3;
	localparam int MAX_OUT = 4;   // longest byte stream a valid character yields

	typedef logic [CP_W-1:0]  cp_t;
	typedef logic [LEN_W-1:0] len_t;
	typedef logic [7:0]       byte_t;

	// Upper bounds of each encoded length
	localparam cp_t LIM_1B   = 32'h0000_007F;
	localparam cp_t LIM_2B   = 32'h0000_07FF;
	localparam cp_t LIM_3B   = 32'h0000_FFFF;
	localparam cp_t LIM_4B   = 32'h001F_FFFF;
	localparam cp_t LIM_5B   = 32'h03FF_FFFF;
	localparam cp_t LIM_6B   = 32'h7FFF_FFFF;
	localparam cp_t LIM_UNI  = 32'h0010_FFFF;
	localparam cp_t NONCHAR0 = 32'h0000_FFFE;
	localparam cp_t NONCHAR1 = 32'h0000_FFFF;

	// Lead and continuation marks
	localparam byte_t MARK_2B   = 8'hC0;
	localparam byte_t MARK_3B   = 8'hE0;
	localparam byte_t MARK_4B   = 8'hF0;
	localparam byte_t MARK_CONT = 8'h80;

	localparam len_t LEN_NONE = 3'd0;
	localparam len_t LEN_1    = 3'd1;
	localparam len_t LEN_2    = 3'd2;
	localparam len_t LEN_3    = 3'd3;
	localparam len_t LEN_4    = 3'd4;
	localparam len_t LEN_5    = 3'd5;
	localparam len_t LEN_6    = 3'd6;

	// Per-request info carried from the classify stage on
	typedef struct packed {
		len_t len;     // encoded length, 0 above 31 bits
		logic bad;     // not an encodable character
		logic query;   // length-only request
	} req_info_t;

endpackage

// ----- design/utf8_code_point_encoder_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_code_point_encoder_top
// Pipelined UTF-8 encoder: one code point in, one to four bytes out.
// ----------------------------------------------------------------------------
// Usage:
//   A request (code_point, size_query) is taken at a rising edge with start
//   high and busy low. Results leave on out_byte/last_byte/byte_count/bad_char
//   for one cycle each, marked by strobe; the receiver cannot stall them.
//   A valid character without size_query gives one result per encoded byte,
//   lead byte first, last_byte on the final one. A query, or any invalid code
//   point, gives a single result with out_byte zero and last_byte set.
// Path: a request passes the capture, classify and byte build stages, then the
//   output shift register, before its first result shows; busy can hold it on the way.
// Throughput: a request holds the output shift register until its last result
//   leaves, so the next request can load only then; single-result requests
//   flow at one per cycle unless a multi-byte stream is in it. busy is high while
//   the last pipeline stage holds a request the shift register cannot yet take.
// Reset: arst_n clears all valid bits and the shift register count; no
//   results are pending after reset.
// ----------------------------------------------------------------------------
module utf8_code_point_encoder_top (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  utf8_enc_pkg::cp_t       code_point,
	input  logic                    size_query,
	output logic                    strobe,
	output utf8_enc_pkg::byte_t     out_byte,
	output logic                    last_byte,
	output utf8_enc_pkg::len_t      byte_count,
	output logic                    bad_char
);
	import utf8_enc_pkg::*;

	// Stage registers
	logic      v_s1, v_s2, v_s3;
	cp_t       cp_s1, cp_s2;
	logic      query_s1;
	req_info_t info_s2, info_s3;
	byte_t     bytes_s3 [MAX_OUT];
	len_t      cnt_s3;

	// Output shift register
	byte_t     bytes_q [MAX_OUT];
	len_t      left_q;
	len_t      len_q;
	logic      bad_q;

	logic      take;
	logic      adv;
	logic      acc;
	len_t      len_c;
	logic      bad_c;
	byte_t     bytes_c [MAX_OUT];
	len_t      cnt_c;

	// Shift register frees up on its last result; the pipe moves as a whole
	assign take = (left_q <= LEN_1);
	assign adv  = !v_s3 || take;
	assign busy = !adv;
	assign acc  = start && !busy;

	// Stage 1: capture request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cp_s1    <= code_point;
			query_s1 <= size_query;
		end
	end

	// Stage 2: classify length and validity
	always_comb begin
		priority if (cp_s1 <= LIM_1B) len_c = LEN_1;
		else if (cp_s1 <= LIM_2B)     len_c = LEN_2;
		else if (cp_s1 <= LIM_3B)     len_c = LEN_3;
		else if (cp_s1 <= LIM_4B)     len_c = LEN_4;
		else if (cp_s1 <= LIM_5B)     len_c = LEN_5;
		else if (cp_s1 <= LIM_6B)     len_c = LEN_6;
		else                          len_c = LEN_NONE;
	end

	assign bad_c = (len_c == LEN_NONE) || (len_c >= LEN_5) ||
		(cp_s1 == NONCHAR0) || (cp_s1 == NONCHAR1) ||
		((len_c == LEN_4) && (cp_s1 > LIM_UNI));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cp_s2         <= cp_s1;
			info_s2.len   <= len_c;
			info_s2.bad   <= bad_c;
			info_s2.query <= query_s1;
		end
	end

	// Stage 3: build the byte stream, lead byte in slot 0
	always_comb begin
		for (int i = 0; i < MAX_OUT; i++) bytes_c[i] = '0;
		cnt_c = LEN_1;
		if (!(info_s2.bad || info_s2.query)) begin
			cnt_c = info_s2.len;
			unique case (info_s2.len)
				LEN_2: begin
					bytes_c[0] = MARK_2B   | {3'b000, cp_s2[10:6]};
					bytes_c[1] = MARK_CONT | {2'b00, cp_s2[5:0]};
				end
				LEN_3: begin
					bytes_c[0] = MARK_3B   | {4'b0000, cp_s2[15:12]};
					bytes_c[1] = MARK_CONT | {2'b00, cp_s2[11:6]};
					bytes_c[2] = MARK_CONT | {2'b00, cp_s2[5:0]};
				end
				LEN_4: begin
					bytes_c[0] = MARK_4B   | {5'b00000, cp_s2[20:18]};
					bytes_c[1] = MARK_CONT | {2'b00, cp_s2[17:12]};
					bytes_c[2] = MARK_CONT | {2'b00, cp_s2[11:6]};
					bytes_c[3] = MARK_CONT | {2'b00, cp_s2[5:0]};
				end
				default: begin
					// single byte; longer forms are always flagged bad
					bytes_c[0] = {1'b0, cp_s2[6:0]};
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			info_s3  <= info_s2;
			bytes_s3 <= bytes_c;
			cnt_s3   <= cnt_c;
		end
	end

	// Output shift register: load on the last result, else shift one byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= LEN_NONE;
		end else if (take) begin
			left_q <= v_s3 ? cnt_s3 : LEN_NONE;
		end else begin
			left_q <= left_q - LEN_1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			bytes_q <= bytes_s3;
			len_q   <= info_s3.len;
			bad_q   <= info_s3.bad;
		end else begin
			for (int i = 0; i < MAX_OUT - 1; i++) bytes_q[i] <= bytes_q[i+1];
			bytes_q[MAX_OUT-1] <= '0;
		end
	end

	assign strobe     = (left_q != LEN_NONE);
	assign out_byte   = bytes_q[0];
	assign last_byte  = (left_q == LEN_1);
	assign byte_count = len_q;
	assign bad_char   = bad_q;

`ifndef ASSERT_OFF
	// stall only arises from a waiting request in the last stage
	a_busy_src: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (v_s3 && strobe && !last_byte))
		else $error("busy without a blocked request");

	// a multi-byte stream continues in the next cycle
	a_stream_cont: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !last_byte) |=> strobe)
		else $error("byte stream broken");

	// length stays fixed across one stream
	a_len_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !last_byte) |=> $stable(byte_count) && $stable(bad_char))
		else $error("length changed mid-stream");

	// error results are single and carry no byte
	a_bad_single: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && bad_char) |-> (last_byte && out_byte == '0))
		else $error("bad character result malformed");

	// streamed results only for encodable lengths
	a_good_len: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !bad_char) |-> (byte_count != LEN_NONE && byte_count <= LEN_4))
		else $error("valid result with illegal length");
`endif

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the UTF-8 code point encoder.
// A driver pushes code point requests from a pending list with random sender
// gaps. Every accepted request is encoded by a local model into the byte
// stream the block should return. The monitor compares each strobed result,
// field by field, with the oldest expected one.
// ----------------------------------------------------------------------------
module tb_top;

	import utf8_enc_pkg::*;

	localparam int CLK_HALF   = 4;
	localparam int RST_CYCLES = 11;
	localparam int DRAIN_WAIT = 20;
	localparam int MAX_CYCLES = 200000;
	localparam int MAX_REPORT = 40;

	// One encode request as the driver presents it
	typedef struct {
		cp_t  cp;
		logic query;
	} enc_req_t;

	// One strobed result of the encoder
	typedef struct packed {
		byte_t data;
		logic  last;
		len_t  count;
		logic  bad;
	} enc_res_t;

	logic  clk        = 1'b0;
	logic  arst_n     = 1'b0;
	logic  start      = 1'b0;
	cp_t   code_point = '0;
	logic  size_query = 1'b0;
	logic  busy;
	logic  strobe;
	byte_t out_byte;
	logic  last_byte;
	len_t  byte_count;
	logic  bad_char;

	enc_req_t pending_reqs[$];
	enc_res_t expected_bytes[$];

	int   send_idle_pct = 9;
	int   drive_cnt     = 0;
	int   cycle_cnt     = 0;
	int   req_cnt       = 0;
	int   query_cnt     = 0;
	int   reject_cnt    = 0;
	int   result_cnt    = 0;
	int   fail_cnt      = 0;

	utf8_code_point_encoder_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.code_point (code_point),
		.size_query (size_query),
		.strobe     (strobe),
		.out_byte   (out_byte),
		.last_byte  (last_byte),
		.byte_count (byte_count),
		.bad_char   (bad_char)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// Encode one request into the results the block must produce
	function automatic void encode_utf8(input cp_t cp, input logic query);
		len_t     len;
		logic     bad;
		cp_t      bits;
		enc_res_t r;
		if (cp <= LIM_1B)      len = LEN_1;
		else if (cp <= LIM_2B) len = LEN_2;
		else if (cp <= LIM_3B) len = LEN_3;
		else if (cp <= LIM_4B) len = LEN_4;
		else if (cp <= LIM_5B) len = LEN_5;
		else if (cp <= LIM_6B) len = LEN_6;
		else                   len = LEN_NONE;
		bad = (len == LEN_NONE) || (len >= LEN_5) || (cp == NONCHAR0) || (cp == NONCHAR1)
			|| (len == LEN_4 && cp > LIM_UNI);
		if (bad) reject_cnt++;
		if (query) query_cnt++;
		// error or query: a single length-only result
		if (bad || query) begin
			r.data  = '0;
			r.last  = 1'b1;
			r.count = len;
			r.bad   = bad;
			expected_bytes.push_back(r);
			return;
		end
		for (int k = 0; k < int'(len); k++) begin
			bits = cp >> (6 * (int'(len) - 1 - k));
			if (len == LEN_1)
				r.data = {1'b0, cp[6:0]};
			else if (k == 0) begin
				case (len)
					LEN_2:   r.data = MARK_2B | bits[7:0];
					LEN_3:   r.data = MARK_3B | bits[7:0];
					default: r.data = MARK_4B | bits[7:0];
				endcase
			end else
				r.data = MARK_CONT | {2'b00, bits[5:0]};
			r.last  = (k == int'(len) - 1);
			r.count = len;
			r.bad   = 1'b0;
			expected_bytes.push_back(r);
		end
	endfunction

	// Random code point, weighted toward each length band and its edges
	function automatic cp_t pick_code_point();
		cp_t edges[10];
		edges = '{LIM_1B, LIM_2B, NONCHAR0, LIM_3B, LIM_UNI, LIM_4B, LIM_5B, LIM_6B,
			32'hFFFF_FFFF, 32'h0000_D7FF};
		case ($urandom_range(0, 11))
			0:       return $urandom_range(0, 32'h7F);
			1:       return $urandom_range(32'h80, 32'h7FF);
			2:       return $urandom_range(32'h800, 32'hFFFF);
			3:       return NONCHAR0 + $urandom_range(0, 1);
			4:       return $urandom_range(32'h1_0000, 32'h10_FFFF);
			5:       return $urandom_range(32'h11_0000, 32'h1F_FFFF);
			6:       return $urandom_range(32'h20_0000, 32'h3FF_FFFF);
			7:       return $urandom_range(32'h400_0000, 32'h7FFF_FFFF);
			8:       return $urandom | 32'h8000_0000;
			9, 10:   return $urandom;
			default: return edges[$urandom_range(0, 9)] + $urandom_range(0, 1);
		endcase
	endfunction

	function automatic void queue_req(input cp_t cp, input logic query);
		enc_req_t r;
		r.cp    = cp;
		r.query = query;
		pending_reqs.push_back(r);
	endfunction

	// Request driver: change inputs on the falling edge; a request is done
	// once the monitor has counted as many accepts as were driven
	always @(negedge clk) begin : drive_req
		enc_req_t nxt;
		if (arst_n && (!start || req_cnt == drive_cnt)) begin
			if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				nxt = pending_reqs.pop_front();
				drive_cnt++;
				start      <= 1'b1;
				code_point <= nxt.cp;
				size_query <= nxt.query;
			end else
				start <= 1'b0;
		end
	end

	// Acceptance, result checking and the cycle limit on the rising edge
	always @(posedge clk) begin : check_res
		enc_res_t got;
		enc_res_t want;
		cycle_cnt++;
		if (cycle_cnt > MAX_CYCLES) begin
			$display("%0t: run exceeded %0d cycles", $time, MAX_CYCLES);
			$display("FAILURE");
			$finish;
		end else if (arst_n) begin
			if (start && !busy) begin
				encode_utf8(code_point, size_query);
				req_cnt++;
			end
			if (strobe) begin
				got = {out_byte, last_byte, byte_count, bad_char};
				result_cnt++;
				if (expected_bytes.size() == 0) begin
					fail_cnt++;
					if (fail_cnt <= MAX_REPORT)
						$display("%0t: unexpected result byte=%h last=%b count=%0d bad=%b",
							$time, got.data, got.last, got.count, got.bad);
				end else begin
					want = expected_bytes.pop_front();
					if (got !== want) begin
						fail_cnt++;
						if (fail_cnt <= MAX_REPORT)
							$display({"%0t: mismatch exp byte=%h last=%b count=%0d bad=%b",
								" got byte=%h last=%b count=%0d bad=%b"}, $time,
								want.data, want.last, want.count, want.bad,
								got.data, got.last, got.count, got.bad);
					end
				end
			end
		end
	end

	// Stimulus phases and end of run
	initial begin
		repeat (RST_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: band edges, noncharacters, oversize forms, queries
		queue_req(32'h0000_0000, 1'b0);
		queue_req(32'h0000_007F, 1'b0);
		queue_req(32'h0000_0080, 1'b0);
		queue_req(32'h0000_07FF, 1'b0);
		queue_req(32'h0000_0800, 1'b0);
		queue_req(32'h0000_20AC, 1'b0);
		queue_req(32'h0000_D800, 1'b0);
		queue_req(32'h0000_FFFD, 1'b0);
		queue_req(NONCHAR0, 1'b0);
		queue_req(NONCHAR1, 1'b0);
		queue_req(32'h0001_0000, 1'b0);
		queue_req(LIM_UNI, 1'b0);
		queue_req(32'h0011_0000, 1'b0);
		queue_req(LIM_4B, 1'b0);
		queue_req(32'h0020_0000, 1'b0);
		queue_req(LIM_5B, 1'b0);
		queue_req(32'h0400_0000, 1'b0);
		queue_req(LIM_6B, 1'b0);
		queue_req(32'h8000_0000, 1'b0);
		queue_req(32'hFFFF_FFFF, 1'b0);
		queue_req(32'h0000_0041, 1'b1);
		queue_req(LIM_UNI, 1'b1);
		queue_req(NONCHAR0, 1'b1);
		queue_req(32'hFFFF_FFFF, 1'b1);

		// random: light sender gaps, then heavy gaps, then back-to-back
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 9 : (ph == 1) ? 84 : 0;
			for (int i = 0; i < 115; i++)
				queue_req(pick_code_point(), $urandom_range(0, 3) == 0);
			while (pending_reqs.size() != 0 || start) @(posedge clk);
		end

		while (pending_reqs.size() != 0 || start || expected_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Encoded %0d code points: %0d length queries, %0d rejected values",
			req_cnt, query_cnt, reject_cnt);
		$display("Checked %0d results over three sender pacing phases, %0d errors",
			result_cnt, fail_cnt);
		if (fail_cnt == 0 && expected_bytes.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
